// ===== sv/i2cbm_pkg.sv =====
package i2cbm_pkg;

   localparam int DelayWidth = 16;
   localparam logic [63:0] DelayMax = (64'd1 << DelayWidth) - 64'd1;
   localparam logic [15:0] PhaseReset = 16'd500;
   localparam logic [7:0] MsbMask = 8'h80;
   localparam logic [7:0] LsbBit = 8'h01;
   localparam logic [3:0] BitsPerByte = 4'd8;

   typedef enum logic [2:0] {
      CMD_START = 3'd0,
      CMD_STOP  = 3'd1,
      CMD_ACK   = 3'd2,
      CMD_NACK  = 3'd3,
      CMD_WACK  = 3'd4,
      CMD_SEND  = 3'd5,
      CMD_RECV  = 3'd6
   } cmd_type;

   localparam logic [2:0] OpcodeUnused = 3'd7;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_BUS_BUSY = 2'd1,
      STAT_BUS_ERR  = 2'd2,
      STAT_NO_ACK   = 2'd3
   } status_type;

   typedef logic [2:0] step_type;

   localparam step_type StepIdle = 3'd0;
   localparam step_type Step1    = 3'd1;
   localparam step_type Step2    = 3'd2;
   localparam step_type Step3    = 3'd3;
   localparam step_type Step4    = 3'd4;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] opcode;
      logic [7:0] tx_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] rx_byte;
   } rsp_type;

endpackage

// ===== sv/i2c_bit_level_master.sv =====
// Command-level I2C master driving SCL and SDA as open-drain levels. Each req
// word is one tick of the pin sequencer: it may carry a command (start, stop,
// ack, nack, wait ack, send byte, receive byte) and always carries the sampled
// SDA level. Every req word yields exactly one rsp word holding the pin drive,
// busy, done, status and last received byte after that tick. One word is taken
// per clock cycle while the result register is free or being taken; a word goes
// through an input register, combinational step logic and a result register.
// Non-final pin steps wait phase_ticks idle ticks (reset 500); the user must write
// phase_ticks via csr_we/csr_wdata only while idle; the block does not enforce it.
module i2c_bit_level_master (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  i2cbm_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output i2cbm_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic [15:0]        csr_wdata
);

   logic               in_valid_ff, in_valid_in;
   i2cbm_pkg::req_type in_data_ff;
   logic               out_valid_ff, out_valid_in;
   i2cbm_pkg::rsp_type out_data_ff;
   logic [15:0]        phase_ff;
   logic               advance;
   logic               step_en;
   i2cbm_pkg::rsp_type step_result;

   // result stage frees when empty or being taken
   assign advance   = !out_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = step_en || (out_valid_ff && !rsp_ready);

   i2cbm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .item        (in_data_ff),
      .phase_ticks (phase_ff),
      .result      (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= i2cbm_pkg::PhaseReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            phase_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (step_en) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   held_word_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ready |=> in_valid_ff)
      else $error("stalled req word dropped");

   done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.done_res && rsp_data.busy_res))
      else $error("done and busy together");

   status_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.done_res |-> rsp_data.status == i2cbm_pkg::STAT_OK)
      else $error("status outside completion");

endmodule

// ===== sv/i2cbm_seq.sv =====
module i2cbm_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  i2cbm_pkg::req_type item,
   input  logic [15:0]       phase_ticks,
   output i2cbm_pkg::rsp_type result
);

   i2cbm_pkg::cmd_type  cmd_ff, cmd_in;
   i2cbm_pkg::step_type step_ff, step_in;
   logic [3:0] bit_cnt_ff, bit_cnt_in;
   logic [i2cbm_pkg::DelayWidth-1:0] tick_ff, tick_in;
   logic [7:0] shift_ff, shift_in;
   logic scl_lvl_ff, scl_lvl_in;
   logic sda_lvl_ff, sda_lvl_in;
   logic [7:0] rx_hold_ff, rx_hold_in;

   logic [63:0] phase_ext;
   logic [i2cbm_pkg::DelayWidth-1:0] load_delay;
   logic run;
   logic fin;
   i2cbm_pkg::status_type st;

   assign phase_ext = {48'd0, phase_ticks};
   // phase saturates at what the counter can hold
   assign load_delay = (phase_ext > i2cbm_pkg::DelayMax) ?
                       i2cbm_pkg::DelayMax[i2cbm_pkg::DelayWidth-1:0] :
                       phase_ext[i2cbm_pkg::DelayWidth-1:0];

   always_comb begin
      cmd_in     = cmd_ff;
      step_in    = step_ff;
      bit_cnt_in = bit_cnt_ff;
      tick_in    = tick_ff;
      shift_in   = shift_ff;
      scl_lvl_in = scl_lvl_ff;
      sda_lvl_in = sda_lvl_ff;
      rx_hold_in = rx_hold_ff;
      run        = 1'b0;
      fin        = 1'b0;
      st         = i2cbm_pkg::STAT_OK;

      if (step_ff == i2cbm_pkg::StepIdle) begin
         if (item.cmd_valid && item.opcode != i2cbm_pkg::OpcodeUnused) begin
            cmd_in     = i2cbm_pkg::cmd_type'(item.opcode);
            bit_cnt_in = 4'd0;
            shift_in   = (item.opcode == i2cbm_pkg::CMD_SEND) ? item.tx_byte : 8'd0;
            step_in    = i2cbm_pkg::Step1;
            run        = 1'b1;
         end
      end else if (tick_ff != '0) begin
         tick_in = tick_ff - 1'b1;
      end else begin
         run = 1'b1;
      end

      if (run) begin
         unique case (cmd_in)
            i2cbm_pkg::CMD_START: begin
               if (step_in == i2cbm_pkg::Step1) begin
                  sda_lvl_in = 1'b1;
                  scl_lvl_in = 1'b1;
               end else if (step_in == i2cbm_pkg::Step2) begin
                  if (!item.sda_in) begin
                     st  = i2cbm_pkg::STAT_BUS_BUSY;
                     fin = 1'b1;
                  end else begin
                     sda_lvl_in = 1'b0;
                  end
               end else if (step_in == i2cbm_pkg::Step3) begin
                  if (item.sda_in) begin
                     st  = i2cbm_pkg::STAT_BUS_ERR;
                     fin = 1'b1;
                  end else begin
                     sda_lvl_in = 1'b0;
                  end
               end else begin
                  fin = 1'b1;
               end
            end
            i2cbm_pkg::CMD_STOP, i2cbm_pkg::CMD_ACK, i2cbm_pkg::CMD_NACK: begin
               if (step_in == i2cbm_pkg::Step1) begin
                  scl_lvl_in = 1'b0;
               end else if (step_in == i2cbm_pkg::Step2) begin
                  sda_lvl_in = (cmd_in == i2cbm_pkg::CMD_NACK);
               end else if (step_in == i2cbm_pkg::Step3) begin
                  scl_lvl_in = 1'b1;
               end else if (step_in == i2cbm_pkg::Step4) begin
                  // stop releases sda, ack and nack pull scl low again
                  if (cmd_in == i2cbm_pkg::CMD_STOP) begin
                     sda_lvl_in = 1'b1;
                  end else begin
                     scl_lvl_in = 1'b0;
                  end
               end else begin
                  fin = 1'b1;
               end
            end
            i2cbm_pkg::CMD_WACK: begin
               if (step_in == i2cbm_pkg::Step1) begin
                  scl_lvl_in = 1'b0;
               end else if (step_in == i2cbm_pkg::Step2) begin
                  sda_lvl_in = 1'b1;
               end else if (step_in == i2cbm_pkg::Step3) begin
                  scl_lvl_in = 1'b1;
               end else begin
                  if (item.sda_in) begin
                     st = i2cbm_pkg::STAT_NO_ACK;
                  end
                  scl_lvl_in = 1'b0;
                  fin        = 1'b1;
               end
            end
            i2cbm_pkg::CMD_SEND: begin
               if (step_in == i2cbm_pkg::Step1) begin
                  scl_lvl_in = 1'b0;
               end else if (step_in == i2cbm_pkg::Step2) begin
                  sda_lvl_in = |(shift_in & i2cbm_pkg::MsbMask);
                  shift_in   = {shift_in[6:0], 1'b0};
               end else if (step_in == i2cbm_pkg::Step3) begin
                  scl_lvl_in = 1'b1;
                  bit_cnt_in = bit_cnt_in + 4'd1;
               end else begin
                  scl_lvl_in = 1'b0;
                  if (bit_cnt_in >= i2cbm_pkg::BitsPerByte) begin
                     fin = 1'b1;
                  end else begin
                     // loop back, next bit starts at step two
                     step_in = i2cbm_pkg::Step1;
                  end
               end
            end
            i2cbm_pkg::CMD_RECV: begin
               if (step_in == i2cbm_pkg::Step1) begin
                  sda_lvl_in = 1'b1;
                  shift_in   = {shift_in[6:0], 1'b0};
                  scl_lvl_in = 1'b0;
               end else if (step_in == i2cbm_pkg::Step2) begin
                  scl_lvl_in = 1'b1;
               end else begin
                  if (item.sda_in) begin
                     shift_in = shift_in | i2cbm_pkg::LsbBit;
                  end
                  bit_cnt_in = bit_cnt_in + 4'd1;
                  scl_lvl_in = 1'b0;
                  if (bit_cnt_in >= i2cbm_pkg::BitsPerByte) begin
                     rx_hold_in = shift_in;
                     fin        = 1'b1;
                  end else begin
                     shift_in = {shift_in[6:0], 1'b0};
                     step_in  = i2cbm_pkg::Step1;
                  end
               end
            end
            default: begin
               fin = 1'b1;
            end
         endcase

         if (fin) begin
            step_in = i2cbm_pkg::StepIdle;
            tick_in = '0;
         end else begin
            step_in = step_in + 3'd1;
            tick_in = load_delay;
         end
      end
   end

   always_comb begin
      result.scl_out  = scl_lvl_in;
      result.sda_out  = sda_lvl_in;
      result.busy_res = (step_in != i2cbm_pkg::StepIdle);
      result.done_res = fin;
      result.status   = fin ? st : i2cbm_pkg::STAT_OK;
      result.rx_byte  = rx_hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff     <= i2cbm_pkg::CMD_START;
         step_ff    <= i2cbm_pkg::StepIdle;
         bit_cnt_ff <= 4'd0;
         tick_ff    <= '0;
         shift_ff   <= 8'd0;
         scl_lvl_ff <= 1'b1;
         sda_lvl_ff <= 1'b1;
         rx_hold_ff <= 8'd0;
      end else if (step_en) begin
         cmd_ff     <= cmd_in;
         step_ff    <= step_in;
         bit_cnt_ff <= bit_cnt_in;
         tick_ff    <= tick_in;
         shift_ff   <= shift_in;
         scl_lvl_ff <= scl_lvl_in;
         sda_lvl_ff <= sda_lvl_in;
         rx_hold_ff <= rx_hold_in;
      end
   end

   step_in_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= i2cbm_pkg::Step4 || (step_ff == 3'd5 && cmd_ff != i2cbm_pkg::CMD_START))
      else $error("sequencer step out of range");

   wait_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      step_ff == i2cbm_pkg::StepIdle |-> tick_ff == '0)
      else $error("delay count left over while idle");

   bit_count_bound: assert property (@(posedge clock) disable iff (reset)
      bit_cnt_ff <= i2cbm_pkg::BitsPerByte)
      else $error("bit counter past one byte");

endmodule
